// File: design/ksmf_pkg.sv
// ----------------------------------------------------------------------------
// ksmf_pkg: shared constants and types
// Keyword table, window size, subscriber table sizing and the command and
// status records passed between the top level and the subscriber table.
// ----------------------------------------------------------------------------
package ksmf_pkg;

  localparam int KEY_LEN     = 9;
  localparam int WIN_LEN     = 8;
  localparam int SEEN_W      = 4;
  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [7:0] KEYWORD [KEY_LEN] = '{
    8'h73, 8'h75, 8'h62, 8'h73, 8'h63, 8'h72, 8'h69, 8'h62, 8'h65
  };

  // One end-of-message decision handed to the subscriber table.
  typedef struct packed {
    logic        append;
    logic        fanout;
    logic [15:0] entry;   // net in the high byte, host in the low byte
  } ksmf_cmd_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } ksmf_stat_t;

endpackage

// File: design/ksmf_cell.sv
// ----------------------------------------------------------------------------
// ksmf_cell: one position of the keyword window
// Holds one text byte, passes it to the older neighbour on each shift and
// extends the running match from the older side with its own comparison.
// ----------------------------------------------------------------------------
module ksmf_cell
  import ksmf_pkg::*;
(
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] key_char,
  input  logic       match_in,
  output logic [7:0] byte_out,
  output logic       match_out
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= byte_in;
    end
  end

  assign byte_out  = held;
  assign match_out = match_in & (held == key_char);

endmodule

// File: design/ksmf_table.sv
// ----------------------------------------------------------------------------
// ksmf_table: subscriber store and fan-out sequencer
// Appends subscribers on request and, on a fan-out, reads the entries out
// in table order into the output register, one copy per free output slot.
// ----------------------------------------------------------------------------
module ksmf_table
  import ksmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ksmf_cmd_t   cmd,
  output ksmf_stat_t  stat,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic        m_tlast
);

  typedef enum logic {IDLE, FANOUT} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] rd_idx;
  logic [15:0]      mem [TABLE_DEPTH];
  logic             out_free;
  logic             is_last;
  logic             can_append;

  assign out_free   = !m_tvalid || m_tready;
  assign is_last    = (CNT_W'(rd_idx) + CNT_W'(1)) == count;
  assign can_append = count < CNT_W'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.append && can_append) begin
      mem[count[IDX_W-1:0]] <= cmd.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      rd_idx   <= '0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (cmd.append && can_append) begin
            count <= count + CNT_W'(1);
          end
          if (cmd.fanout && count != '0) begin
            rd_idx <= '0;
            state  <= FANOUT;
          end
        end
        FANOUT: begin
          if (out_free) begin
            // Entry is stored in table order, so the net leads the host.
            m_tdata  <= {mem[rd_idx][7:0], mem[rd_idx][15:8]};
            m_tvalid <= 1'b1;
            m_tlast  <= is_last;
            if (is_last) begin
              state <= IDLE;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign stat.busy  = (state == FANOUT);
  assign stat.count = count;

endmodule

// File: design/keyword_subscribe_multicast_fanout.sv
// ----------------------------------------------------------------------------
// keyword_subscribe_multicast_fanout: keyword subscription with fan-out
// Scans message text for the keyword "subscribe" through a chain of window
// cells, adds subscribers and fans out copy descriptors at message end.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while no fan-out is under way; an end
// of message that fans out holds s_tready low until the last subscriber's
// copy descriptor is registered, and m_tready stalls prolong that. The first
// descriptor is registered in the FANOUT state; subscriptions take effect on the next cycle.
// Reset: rst clears the message scan state and the subscriber count; table
// contents are left as they are and only written entries are ever read.
module keyword_subscribe_multicast_fanout
  import ksmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // text_byte, sender_net, sender_host
  input  logic        s_tlast,
  input  logic        s_tuser,   // byte_valid
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // copy_net, copy_host
  output logic        m_tlast
);

  logic              accept;
  logic [7:0]        text_byte;
  logic [7:0]        cell_byte  [WIN_LEN];
  logic              cell_match [WIN_LEN];
  logic [SEEN_W-1:0] bytes_seen;
  logic              keyword_found;
  logic              seen_full;
  logic              hit;
  logic              found_now;
  ksmf_cmd_t         cmd;
  ksmf_stat_t        stat;

  assign accept    = s_tvalid && s_tready;
  assign text_byte = s_tdata[7:0];
  assign s_tready  = !stat.busy;

  // Cell 0 holds the oldest byte; the newest byte enters at the top cell.
  for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
    logic [7:0] next_byte;
    logic       prev_match;
    if (i == WIN_LEN - 1) begin : g_top
      assign next_byte = text_byte;
    end else begin : g_mid
      assign next_byte = cell_byte[i+1];
    end
    if (i == 0) begin : g_first
      assign prev_match = 1'b1;
    end else begin : g_rest
      assign prev_match = cell_match[i-1];
    end
    ksmf_cell u_cell (
      .clk      (clk),
      .shift_en (accept && s_tuser),
      .byte_in  (next_byte),
      .key_char (KEYWORD[i]),
      .match_in (prev_match),
      .byte_out (cell_byte[i]),
      .match_out(cell_match[i])
    );
  end

  assign seen_full = (bytes_seen == SEEN_W'(WIN_LEN));
  assign hit       = s_tuser && seen_full && cell_match[WIN_LEN-1]
                     && (text_byte == KEYWORD[KEY_LEN-1]);
  assign found_now = keyword_found || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      keyword_found <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        bytes_seen    <= '0;
        keyword_found <= 1'b0;
      end else if (s_tuser) begin
        if (!seen_full) begin
          bytes_seen <= bytes_seen + SEEN_W'(1);
        end
        keyword_found <= found_now;
      end
    end
  end

  assign cmd.append = accept && s_tlast && found_now;
  assign cmd.fanout = accept && s_tlast && !found_now;
  assign cmd.entry  = {s_tdata[15:8], s_tdata[23:16]};

  ksmf_table u_table (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  a_fanout_holds_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.fanout && stat.count != '0) |=> !s_tready)
    else $error("input not held after a fan-out request");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(TABLE_DEPTH))
    else $error("subscriber count beyond table depth");

  a_copy_from_fanout: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(stat.busy))
    else $error("copy descriptor issued outside a fan-out");

  a_no_append_while_busy: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !cmd.append)
    else $error("subscription taken during a fan-out");

endmodule
